// File: src/mt_pkg.sv
package mt_pkg;

    localparam int STATE_WORDS = 624;
    localparam int SHIFT_M     = 397;
    localparam int IDX_W       = 10;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7FFF_FFFF;
    localparam logic [31:0] SEED_RESET   = 32'd5489;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(STATE_WORDS - SHIFT_M);
    localparam logic [IDX_W-1:0] M_OFS    = IDX_W'(SHIFT_M);

    localparam logic [1:0] OP_RAW  = 2'd0;
    localparam logic [1:0] OP_MOD  = 2'd1;
    localparam logic [1:0] OP_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] bound;
    } cmd_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] x;
        x = w ^ (w >> 11);
        x = x ^ ((x << 7) & TEMPER_B);
        x = x ^ ((x << 15) & TEMPER_C);
        x = x ^ (x >> 18);
        return x;
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] w0, input logic [31:0] w1,
                                          input logic [31:0] wm);
        logic [31:0] y;
        logic [31:0] v;
        y = (w0 & HIGH_BIT) | (w1 & LOW_BITS);
        v = wm ^ (y >> 1);
        if (w1[0])
        begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

endpackage

// File: src/mt_ram.sv
module mt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/mt_front.sv
module mt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          bounded,
    input  logic [30:0]   upper_bound,
    input  logic          pop,
    output logic          busy,
    output logic          cmd_valid,
    output mt_pkg::cmd_t  cmd
);

    mt_pkg::cmd_t q_reg [2];
    logic         rd_ptr_reg, rd_ptr_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push;
    mt_pkg::cmd_t new_cmd;

    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // A zero bound in bounded mode is settled here so the back end draws nothing.
    always_comb
    begin
        new_cmd.bound = upper_bound;
        if (!bounded)
        begin
            new_cmd.op = mt_pkg::OP_RAW;
        end
        else if (upper_bound == 31'd0)
        begin
            new_cmd.op = mt_pkg::OP_ZERO;
        end
        else
        begin
            new_cmd.op = mt_pkg::OP_MOD;
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ (pop && cmd_valid);
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop && cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push)
        else $error("queue written while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> rd_ptr_reg == wr_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: src/mt_back.sv
module mt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seed_load,
    input  logic [31:0]   seed,
    input  logic          cmd_valid,
    input  mt_pkg::cmd_t  cmd,
    output logic          pop,
    output logic [31:0]   value,
    output logic          done
);

    localparam logic [3:0] S_SEED0 = 4'd0;
    localparam logic [3:0] S_SMUL  = 4'd1;
    localparam logic [3:0] S_SWR   = 4'd2;
    localparam logic [3:0] S_IDLE  = 4'd3;
    localparam logic [3:0] S_RA    = 4'd4;
    localparam logic [3:0] S_RB    = 4'd5;
    localparam logic [3:0] S_RC    = 4'd6;
    localparam logic [3:0] S_TW    = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [mt_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [mt_pkg::IDX_W-1:0] k_reg, k_next;
    logic [31:0]             prev_reg, prev_next;
    logic [31:0]             prod_reg, prod_next;
    logic [31:0]             w0_reg, w0_next;
    logic [31:0]             w1_reg, w1_next;
    logic [31:0]             dvd_reg, dvd_next;
    logic [31:0]             rem_reg, rem_next;
    logic [4:0]              cnt_reg, cnt_next;
    mt_pkg::cmd_t            cur_reg, cur_next;
    logic [31:0]             value_reg, value_next;
    logic                    done_reg, done_next;

    logic                    we;
    logic [mt_pkg::IDX_W-1:0] waddr, raddr;
    logic [31:0]             wdata, rdata;
    logic [mt_pkg::IDX_W-1:0] idx_p1, idx_m;
    logic [31:0]             new_word, tempered, seed_word, sh;
    logic                    ge;

    mt_ram #(.WIDTH(32), .DEPTH(mt_pkg::STATE_WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Words below idx already hold the new round, which is what the twist expects.
    assign idx_p1 = (idx_reg == mt_pkg::LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign idx_m  = (idx_reg < mt_pkg::WRAP_IDX) ? idx_reg + mt_pkg::M_OFS
                                                 : idx_reg - mt_pkg::WRAP_IDX;
    assign new_word  = mt_pkg::twist(w0_reg, w1_reg, rdata);
    assign tempered  = mt_pkg::temper(new_word);
    assign seed_word = prod_reg + {{(32-mt_pkg::IDX_W){1'b0}}, k_reg};
    assign sh        = {rem_reg[30:0], dvd_reg[31]};
    assign ge        = (sh >= {1'b0, cur_reg.bound});

    assign value = value_reg;
    assign done  = done_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        w0_next    = w0_reg;
        w1_next    = w1_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = new_word;
        raddr      = idx_reg;
        unique case (state_reg)
            S_SEED0:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = seed;
                prev_next  = seed;
                k_next     = mt_pkg::IDX_W'(1);
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                prod_next  = mt_pkg::SEED_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = S_SWR;
            end
            S_SWR:
            begin
                we        = 1'b1;
                waddr     = k_reg;
                wdata     = seed_word;
                prev_next = seed_word;
                if (k_reg == mt_pkg::LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SMUL;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop      = 1'b1;
                    cur_next = cmd;
                    if (cmd.op == mt_pkg::OP_ZERO)
                    begin
                        value_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RA;
                    end
                end
            end
            S_RA:
            begin
                raddr      = idx_reg;
                state_next = S_RB;
            end
            S_RB:
            begin
                raddr      = idx_p1;
                w0_next    = rdata;
                state_next = S_RC;
            end
            S_RC:
            begin
                raddr      = idx_m;
                w1_next    = rdata;
                state_next = S_TW;
            end
            S_TW:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = new_word;
                idx_next = idx_p1;
                if (cur_reg.op == mt_pkg::OP_MOD)
                begin
                    dvd_next   = tempered;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    value_next = tempered;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? sh - {1'b0, cur_reg.bound} : sh;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    value_next = rem_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_SEED0;
            end
        endcase
        // A reseed leaves queued requests in place until the fill is over.
        if (seed_load)
        begin
            state_next = S_SEED0;
            done_next  = 1'b0;
            pop        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SEED0;
            idx_reg   <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        prod_reg  <= prod_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        cur_reg   <= cur_next;
        value_reg <= value_next;
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= mt_pkg::LAST_IDX && k_reg <= mt_pkg::LAST_IDX)
        else $error("word index out of range");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_IDLE)
        else $error("command taken while engine busy");
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_IDLE || $past(state_reg) == S_TW
                     || $past(state_reg) == S_DIV)
        else $error("beat issued from wrong state");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {1'b0, cur_reg.bound})
        else $error("partial remainder not reduced");
`endif

endmodule

// File: src/mersenne_twister_prng.sv
// MT19937 random number generator with a command-style request channel.
// A request beat is taken at a rising edge with start high and busy low;
// bounded selects a result modulo upper_bound (a zero bound gives 0) or
// the raw tempered 32-bit word. Each request yields exactly one result
// beat unless a seed write cuts it off in flight: value is valid for the
// single cycle in which done is high, and the receiver cannot hold it
// off. Results come in request order. Requests go into a two-entry queue;
// busy is high only while it is full. A raw draw goes from the queue head
// to done through three reads of the single-read-port state memory, then
// the twist and temper of one word; a bounded draw then reduces that word
// in the bit-serial remainder unit; a zero bound is answered without a
// draw. One request is served at a time while the queue takes new ones.
// After reset and after each write of the seed register at APB addresses
// 0 to 3 (paddr[2] low), the state memory is refilled from the seed;
// queued requests wait and are served after the fill. The seed resets to 5489.
module mersenne_twister_prng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        bounded,
    input  logic [30:0] upper_bound,
    output logic [31:0] value,
    output logic        done
);

    logic [31:0]  seed_reg;
    logic         seed_load;
    logic         cmd_valid;
    logic         pop;
    mt_pkg::cmd_t cmd;

    assign pready    = 1'b1;
    assign seed_load = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mt_pkg::SEED_RESET;
        end
        else if (seed_load)
        begin
            seed_reg <= pwdata;
        end
    end

    mt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .bounded     (bounded),
        .upper_bound (upper_bound),
        .pop         (pop),
        .busy        (busy),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    mt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_load (seed_load),
        .seed      (seed_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .value     (value),
        .done      (done)
    );

endmodule
